@@ rtl/htw_pkg.sv @@
package htw_pkg;

	localparam int ENTRY_W    = 5;
	localparam int INTERVAL_W = 24;
	localparam int KIND_W     = 3;
	localparam int POOL_SIZE  = 20;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_GRAB   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_GRAB   = 3'd4;

	typedef struct packed {
		logic [1:0]            command;
		logic [ENTRY_W-1:0]    entry;
		logic [INTERVAL_W-1:0] interval;
	} htw_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ENTRY_W-1:0] timer_id;
		logic               was_pending;
		logic               pool_full;
		logic               last;
	} htw_res_t;

endpackage

@@ rtl/htw_stream_if.sv @@
interface htw_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

@@ rtl/htw_ram.sv @@
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/hashed_timing_wheel_timers_unit.sv @@
// Timer engine on a hashed timing wheel.
// Commands arrive as beats on the cmd channel (tick, set, cancel, grab) and
// results leave as beats on the res channel; the final result of a command
// has last set. The block takes one command at a time: cmd.ready is high
// only while no command is in progress.
// A set or grab of an entry that is not queued runs SET1, SETW, SET2, DONE;
// when the entry is queued it first runs the unlink states ULW, UL1, ULW2,
// UL2. A cancel, an out-of-range set and a grab on a full pool go straight
// to DONE; a cancel that unlinks runs the unlink states first. A tick runs
// TKW, TK0, then TK1 and WALK for each entry of a nonempty spoke, one fired
// result per matching entry in list order, then the tick result.
// The walk is bound by the read latency of the link memories: each list
// step reads the entry's expiry and links; a firing one writes the unlink.
// Reset clears the tick counter, all entry flags and all spoke nonempty
// flags; link and expiry memories need no clearing.
// A result is held in an output register until res.ready; while it waits
// the sequencer stalls before producing the next result.
module hashed_timing_wheel_timers_unit
	import htw_pkg::*;
#(
	parameter int TIMER_ENTRIES = 32,
	parameter int WHEEL_BITS    = 8,
	parameter int TICK_BITS     = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	htw_stream_if.sink   cmd,
	htw_stream_if.source res
);
	localparam int IW     = $clog2(TIMER_ENTRIES);
	localparam int SPOKES = 1 << WHEEL_BITS;
	localparam int LIM    = (POOL_SIZE < TIMER_ENTRIES) ? POOL_SIZE : TIMER_ENTRIES;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ULW    = 4'd1;
	localparam logic [3:0] ST_UL1    = 4'd2;
	localparam logic [3:0] ST_ULW2   = 4'd3;
	localparam logic [3:0] ST_UL2    = 4'd4;
	localparam logic [3:0] ST_SET1   = 4'd5;
	localparam logic [3:0] ST_SETW   = 4'd6;
	localparam logic [3:0] ST_SET2   = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;
	localparam logic [3:0] ST_TKW    = 4'd9;
	localparam logic [3:0] ST_TK0    = 4'd10;
	localparam logic [3:0] ST_TK1    = 4'd11;
	localparam logic [3:0] ST_WALK   = 4'd12;
	localparam logic [3:0] ST_TKDONE = 4'd13;

	logic [3:0]               state_q;
	logic [TICK_BITS-1:0]     tc_q;
	logic [TIMER_ENTRIES-1:0] act_q, pend_q, pool_q;
	logic [SPOKES-1:0]        ne_q;
	logic [IW-1:0]            t_q;
	logic [WHEEL_BITS-1:0]    s_q;
	logic [1:0]               cmd_q;
	logic [ENTRY_W-1:0]       ent_q;
	logic [INTERVAL_W-1:0]    ivl_q;
	logic                     wp_q, full_q;
	logic                     ov_q;
	htw_res_t                 res_q;

	logic                 exp_we, nxt_we, prv_we, ht_we;
	logic [IW-1:0]        nxt_wa, prv_wa;
	logic [IW-1:0]        nxt_wd, prv_wd;
	logic [2*IW-1:0]      ht_wd, ht_rd;
	logic [TICK_BITS-1:0] exp_wd, exp_rd;
	logic [IW-1:0]        nxt_rd, prv_rd;

	htw_ram #(.WIDTH(TICK_BITS), .DEPTH(TIMER_ENTRIES)) u_exp (
		.clk(clk), .we(exp_we), .waddr(t_q), .wdata(exp_wd), .raddr(t_q), .rdata(exp_rd));
	htw_ram #(.WIDTH(IW), .DEPTH(TIMER_ENTRIES)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(t_q), .rdata(nxt_rd));
	htw_ram #(.WIDTH(IW), .DEPTH(TIMER_ENTRIES)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(t_q), .rdata(prv_rd));
	htw_ram #(.WIDTH(2*IW), .DEPTH(SPOKES)) u_ht (
		.clk(clk), .we(ht_we), .waddr(s_q), .wdata(ht_wd), .raddr(s_q), .rdata(ht_rd));

	logic [IW-1:0]        hd, tl;
	logic                 is_head, is_tail, fire, can_emit, ent_ok, g_found;
	logic                 emit_res;
	logic [IW-1:0]        g_idx, ent_idx;
	logic [TICK_BITS-1:0] new_exp, tc_nx;

	assign hd       = ht_rd[2*IW-1:IW];
	assign tl       = ht_rd[IW-1:0];
	assign is_head  = (hd == t_q);
	assign is_tail  = (tl == t_q);
	assign fire     = (exp_rd == tc_q);
	assign can_emit = !ov_q || res.ready;
	assign emit_res = can_emit && ((state_q == ST_DONE) || (state_q == ST_TKDONE) ||
		(state_q == ST_WALK && fire));
	assign ent_ok   = 32'(cmd.data.entry) < TIMER_ENTRIES;
	assign ent_idx  = IW'(cmd.data.entry);
	assign new_exp  = tc_q + TICK_BITS'(ivl_q) + TICK_BITS'(1);
	assign tc_nx    = tc_q + TICK_BITS'(1);
	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = ov_q;
	assign res.data  = res_q;

	always_comb begin
		g_found = 1'b0;
		g_idx   = '0;
		for (int i = LIM - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				g_found = 1'b1;
				g_idx   = IW'(i);
			end
		end
	end

	// Writes: expiry in SET1, unlink in UL2 and a firing walk step, append in SET2.
	always_comb begin
		exp_we = 1'b0;
		exp_wd = new_exp;
		nxt_we = 1'b0;
		nxt_wa = prv_rd;
		nxt_wd = nxt_rd;
		prv_we = 1'b0;
		prv_wa = nxt_rd;
		prv_wd = prv_rd;
		ht_we  = 1'b0;
		ht_wd  = {is_head ? nxt_rd : hd, is_tail ? prv_rd : tl};
		if (state_q == ST_UL2 || (state_q == ST_WALK && fire && can_emit)) begin
			if (!(is_head && is_tail)) begin
				ht_we  = is_head || is_tail;
				nxt_we = !is_head;
				prv_we = !is_tail;
			end
		end else if (state_q == ST_SET1) begin
			exp_we = 1'b1;
		end else if (state_q == ST_SET2) begin
			ht_we = 1'b1;
			if (ne_q[s_q]) begin
				ht_wd  = {hd, t_q};
				nxt_we = 1'b1;
				nxt_wa = tl;
				nxt_wd = t_q;
				prv_we = 1'b1;
				prv_wa = t_q;
				prv_wd = tl;
			end else begin
				ht_wd = {t_q, t_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tc_q    <= '0;
			act_q   <= '0;
			pend_q  <= '0;
			pool_q  <= '0;
			ne_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit_res) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q  <= cmd.data.command;
						ent_q  <= cmd.data.entry;
						ivl_q  <= cmd.data.interval;
						wp_q   <= 1'b0;
						full_q <= 1'b0;
						t_q    <= ent_idx;
						unique case (cmd.data.command)
							CMD_TICK: begin
								tc_q    <= tc_nx;
								s_q     <= tc_nx[WHEEL_BITS-1:0];
								state_q <= ST_TKW;
							end
							CMD_SET: begin
								if (!ent_ok) begin
									state_q <= ST_DONE;
								end else if (pend_q[ent_idx]) begin
									state_q <= ST_ULW;
								end else begin
									state_q <= ST_SET1;
								end
							end
							CMD_CANCEL: begin
								if (ent_ok) begin
									act_q[ent_idx] <= 1'b0;
									wp_q           <= pend_q[ent_idx];
								end
								state_q <= (ent_ok && pend_q[ent_idx]) ? ST_ULW : ST_DONE;
							end
							CMD_GRAB: begin
								t_q <= g_idx;
								if (!g_found) begin
									full_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									pool_q[g_idx] <= 1'b1;
									state_q <= pend_q[g_idx] ? ST_ULW : ST_SET1;
								end
							end
						endcase
					end
				end
				ST_ULW: state_q <= ST_UL1;
				ST_UL1: begin
					s_q     <= exp_rd[WHEEL_BITS-1:0];
					state_q <= ST_ULW2;
				end
				ST_ULW2: state_q <= ST_UL2;
				ST_UL2: begin
					if (is_head && is_tail) begin
						ne_q[s_q] <= 1'b0;
					end
					pend_q[t_q] <= 1'b0;
					state_q <= (cmd_q == CMD_CANCEL) ? ST_DONE : ST_SET1;
				end
				ST_SET1: begin
					act_q[t_q]  <= 1'b1;
					pend_q[t_q] <= 1'b1;
					s_q         <= new_exp[WHEEL_BITS-1:0];
					state_q     <= ST_SETW;
				end
				ST_SETW: state_q <= ST_SET2;
				ST_SET2: begin
					ne_q[s_q] <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (can_emit) begin
						res_q.was_pending <= wp_q;
						res_q.pool_full   <= full_q;
						res_q.last        <= 1'b1;
						res_q.timer_id    <= ent_q;
						unique case (cmd_q)
							CMD_SET:    res_q.kind <= KIND_SET;
							CMD_CANCEL: res_q.kind <= KIND_CANCEL;
							default: begin
								res_q.kind     <= KIND_GRAB;
								res_q.timer_id <= full_q ? '0 : ENTRY_W'(t_q);
							end
						endcase
						state_q <= ST_IDLE;
					end
				end
				ST_TKW: state_q <= ST_TK0;
				ST_TK0: begin
					t_q     <= hd;
					state_q <= ne_q[s_q] ? ST_TK1 : ST_TKDONE;
				end
				ST_TK1: state_q <= ST_WALK;
				ST_WALK: begin
					if (!fire || can_emit) begin
						if (fire) begin
							if (is_head && is_tail) begin
								ne_q[s_q] <= 1'b0;
							end
							pend_q[t_q] <= 1'b0;
							if (pool_q[t_q]) begin
								act_q[t_q] <= 1'b0;
							end
							res_q.kind        <= KIND_FIRED;
							res_q.timer_id    <= ENTRY_W'(t_q);
							res_q.was_pending <= 1'b0;
							res_q.pool_full   <= 1'b0;
							res_q.last        <= 1'b0;
						end
						t_q     <= is_tail ? t_q : nxt_rd;
						state_q <= is_tail ? ST_TKDONE : ST_TK1;
					end
				end
				ST_TKDONE: begin
					if (can_emit) begin
						res_q.kind        <= KIND_TICK;
						res_q.timer_id    <= '0;
						res_q.was_pending <= 1'b0;
						res_q.pool_full   <= 1'b0;
						res_q.last        <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ dv/htw_checker.sv @@
module htw_checker
	import htw_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	htw_stream_if.monitor  cmd_mon,
	htw_stream_if.monitor  res_mon,
	input  logic           drain_check,
	output int             mismatch_count,
	output int             awaiting_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 32;
	localparam int SPOKES  = 256;

	logic [31:0]        tick_now;
	logic [31:0]        deadline [ENTRIES];
	bit                 armed [ENTRIES];
	bit                 queued [ENTRIES];
	bit                 from_pool [ENTRIES];
	logic [ENTRY_W-1:0] fwd [ENTRIES];
	logic [ENTRY_W-1:0] bwd [ENTRIES];
	logic [ENTRY_W-1:0] head [SPOKES];
	logic [ENTRY_W-1:0] tail [SPOKES];
	bit                 occupied [SPOKES];
	htw_res_t           due_results [$];
	bit                 drained;

	task automatic report(input string msg);
		$display("error at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic htw_res_t make_res(logic [KIND_W-1:0] k, logic [ENTRY_W-1:0] id,
			logic wp, logic full, logic lst);
		htw_res_t r;
		r.kind = k;
		r.timer_id = id;
		r.was_pending = wp;
		r.pool_full = full;
		r.last = lst;
		return r;
	endfunction

	function automatic void detach(int t);
		int s;
		bit is_head;
		bit is_tail;
		s = int'(deadline[t][7:0]);
		is_head = head[s] == t;
		is_tail = tail[s] == t;
		if (is_head && is_tail) begin
			occupied[s] = 0;
		end else begin
			if (is_head) head[s] = fwd[t];
			else fwd[bwd[t]] = fwd[t];
			if (is_tail) tail[s] = bwd[t];
			else bwd[fwd[t]] = bwd[t];
		end
		queued[t] = 0;
	endfunction

	function automatic bit disarm(int t);
		bit was;
		was = queued[t];
		armed[t] = 0;
		if (was) detach(t);
		return was;
	endfunction

	function automatic void arm(int t, logic [INTERVAL_W-1:0] ivl);
		int s;
		bit unused;
		if (armed[t] || queued[t]) unused = disarm(t);
		armed[t] = 1;
		queued[t] = 1;
		deadline[t] = tick_now + 32'(ivl) + 32'd1;
		s = int'(deadline[t][7:0]);
		if (occupied[s]) begin
			fwd[tail[s]] = ENTRY_W'(t);
			bwd[t] = tail[s];
		end else begin
			head[s] = ENTRY_W'(t);
			occupied[s] = 1;
		end
		tail[s] = ENTRY_W'(t);
	endfunction

	function automatic void predict(htw_cmd_t c);
		int s;
		int t;
		int nx;
		int i;
		bit at_end;
		case (c.command)
			CMD_TICK: begin
				tick_now = tick_now + 32'd1;
				s = int'(tick_now[7:0]);
				if (occupied[s]) begin
					t = int'(head[s]);
					for (int step = 0; step < ENTRIES; step++) begin
						at_end = tail[s] == t;
						nx = int'(fwd[t]);
						if (deadline[t] == tick_now) begin
							detach(t);
							if (from_pool[t]) armed[t] = 0;
							due_results.push_back(make_res(KIND_FIRED, ENTRY_W'(t), 0, 0, 0));
						end
						if (at_end || !occupied[s]) break;
						t = nx;
					end
				end
				due_results.push_back(make_res(KIND_TICK, 0, 0, 0, 1));
			end
			CMD_SET: begin
				arm(int'(c.entry), c.interval);
				due_results.push_back(make_res(KIND_SET, c.entry, 0, 0, 1));
			end
			CMD_CANCEL: begin
				due_results.push_back(make_res(KIND_CANCEL, c.entry, disarm(int'(c.entry)),
					0, 1));
			end
			default: begin
				for (i = 0; i < POOL_SIZE; i++)
					if (!armed[i]) break;
				if (i == POOL_SIZE) begin
					due_results.push_back(make_res(KIND_GRAB, 0, 0, 1, 1));
				end else begin
					from_pool[i] = 1;
					arm(i, c.interval);
					due_results.push_back(make_res(KIND_GRAB, ENTRY_W'(i), 0, 0, 1));
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				armed[i] = 0;
				queued[i] = 0;
				from_pool[i] = 0;
			end
			for (int i = 0; i < SPOKES; i++) occupied[i] = 0;
			due_results.delete();
			awaiting_count = 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result beat %p", res_mon.data));
				end else begin
					htw_res_t e;
					e = due_results.pop_front();
					if (res_mon.data.kind !== e.kind)
						report($sformatf("kind %0d, want %0d", res_mon.data.kind, e.kind));
					if (res_mon.data.timer_id !== e.timer_id)
						report($sformatf("timer_id %0d, want %0d",
							res_mon.data.timer_id, e.timer_id));
					if (res_mon.data.was_pending !== e.was_pending)
						report($sformatf("was_pending %b, want %b",
							res_mon.data.was_pending, e.was_pending));
					if (res_mon.data.pool_full !== e.pool_full)
						report($sformatf("pool_full %b, want %b",
							res_mon.data.pool_full, e.pool_full));
					if (res_mon.data.last !== e.last)
						report($sformatf("last %b, want %b", res_mon.data.last, e.last));
				end
			end
			if (cmd_mon.valid && cmd_mon.ready) predict(cmd_mon.data);
			if (drain_check && !drained) begin
				drained = 1;
				if (due_results.size() != 0)
					report($sformatf("%0d results never arrived", due_results.size()));
			end
			awaiting_count = due_results.size();
		end
	end

	initial begin
		mismatch_count = 0;
		awaiting_count = 0;
		drained = 0;
	end
endmodule

@@ dv/testbench.sv @@
module testbench
	import htw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 0;
	logic arst_n = 0;
	logic drain_check = 0;
	int   mismatch_count;
	int   awaiting_count;
	int   cycles = 0;
	bit   sending_done = 0;

	htw_stream_if #(.payload_t(htw_cmd_t)) cmd_ch ();
	htw_stream_if #(.payload_t(htw_res_t)) res_ch ();

	hashed_timing_wheel_timers_unit dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .res(res_ch.source)
	);

	htw_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .cmd_mon(cmd_ch.monitor), .res_mon(res_ch.monitor),
		.drain_check(drain_check), .mismatch_count(mismatch_count),
		.awaiting_count(awaiting_count)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_command(logic [1:0] c, logic [ENTRY_W-1:0] e,
			logic [INTERVAL_W-1:0] ivl, bit idle_ok);
		int gap;
		htw_cmd_t beat;
		beat.command = c;
		beat.entry = e;
		beat.interval = ivl;
		cmd_ch.valid <= 1;
		cmd_ch.data <= beat;
		do @(posedge clk); while (!cmd_ch.ready);
		gap = idle_ok ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [INTERVAL_W-1:0] pick_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return INTERVAL_W'($urandom_range(0, 12));
		if (r < 82) return INTERVAL_W'($urandom_range(250, 262));
		if (r < 95) return INTERVAL_W'($urandom());
		return r[0] ? '1 : '0;
	endfunction

	initial begin
		int beats;
		res_ch.ready = 0;
		@(negedge arst_n or posedge arst_n);
		wait (arst_n);
		beats = 0;
		forever begin
			@(posedge clk);
			beats++;
			if (beats == 400) begin
				res_ch.ready <= 0;
				repeat (300) @(posedge clk);
			end
			if (beats > 1500 && beats < 2500)
				res_ch.ready <= 1;
			else
				res_ch.ready <= ($urandom_range(0, 99) < 70) ||
					(pick_gap() == 0 && $urandom_range(0, 1) == 1);
		end
	end

	initial begin
		int r;
		cmd_ch.valid = 0;
		cmd_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < 21; i++)
			send_command(CMD_GRAB, 0, i == 0 ? '1 : INTERVAL_W'(i), 1);
		send_command(CMD_CANCEL, 25, 0, 1);
		send_command(CMD_SET, 31, 0, 0);
		send_command(CMD_SET, 30, 0, 0);
		send_command(CMD_SET, 30, 1, 1);
		send_command(CMD_TICK, 0, 0, 0);
		send_command(CMD_SET, 31, '1, 1);
		send_command(CMD_TICK, 0, 0, 1);
		send_command(CMD_CANCEL, 31, 0, 1);
		send_command(CMD_CANCEL, 0, 0, 1);
		send_command(CMD_GRAB, 0, 0, 1);
		send_command(CMD_TICK, 0, 0, 1);

		for (int n = 0; n < 500; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				send_command(CMD_TICK, ENTRY_W'($urandom()), INTERVAL_W'($urandom()), 1);
			else if (r < 70)
				send_command(CMD_SET,
					ENTRY_W'(r[0] ? $urandom_range(0, 7) : $urandom()),
					pick_interval(), 1);
			else if (r < 85)
				send_command(CMD_CANCEL,
					ENTRY_W'(r[0] ? $urandom_range(0, 7) : $urandom()),
					INTERVAL_W'($urandom()), 1);
			else
				send_command(CMD_GRAB, ENTRY_W'($urandom()), pick_interval(), 1);
		end
		cmd_ch.valid <= 0;

		while (awaiting_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		drain_check <= 1;
		repeat (2) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

@@ hashed_timing_wheel_timers_unit.f @@
rtl/htw_pkg.sv
rtl/htw_stream_if.sv
rtl/htw_ram.sv
rtl/hashed_timing_wheel_timers_unit.sv
dv/htw_checker.sv
dv/testbench.sv
